// File: src/uv_sphere_vertex_and_index_generator_top_assert.svh
// Assertion macros shared by the RTL files.
`ifndef UV_SPHERE_VERTEX_AND_INDEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_VERTEX_AND_INDEX_GENERATOR_TOP_ASSERT_SVH

// Condition must never hold outside reset.
`define UVS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define UVS_ASSERT_IMPLY(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define UVS_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

// File: src/uvs_pkg.sv
package uvs_pkg;

	localparam int MAX_SEGMENTS     = 255;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int Q_DEPTH          = 4;
	localparam int ONE_Q14          = 16384;
	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

	// item kinds
	localparam logic FUNC_VERTEX = 1'b0;
	localparam logic FUNC_QUAD   = 1'b1;

	// register indexes
	localparam logic [1:0] REG_X_SEGMENTS   = 2'd0;
	localparam logic [1:0] REG_Y_SEGMENTS   = 2'd1;
	localparam logic [1:0] REG_VERTEX_COLOR = 2'd2;

	typedef struct packed {
		logic        func;
		logic [7:0]  gx;
		logic [7:0]  gy;
		logic [15:0] tl;
		logic [15:0] bl;
	} entry_t;

	typedef struct packed {
		logic        func;
		logic        last;
		logic [15:0] index;
	} tag_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_z;
		logic signed [15:0] binormal_x;
		logic signed [15:0] binormal_y;
		logic signed [15:0] binormal_z;
		logic [15:0]        vertex_index;
		logic               last;
	} result_t;

	// arctangent of 2^-i in 2^-32 turn units
	function automatic logic [29:0] atan_turn(input int i);
		logic [29:0] r;
		case (i)
			0: r = 30'd536870912;
			1: r = 30'd316933406;
			2: r = 30'd167458907;
			3: r = 30'd85004756;
			4: r = 30'd42667331;
			5: r = 30'd21354465;
			6: r = 30'd10679838;
			7: r = 30'd5340245;
			8: r = 30'd2670163;
			9: r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// clip to plus or minus one in Q1.14
	function automatic logic signed [15:0] sat_q14(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd16384) begin
			r = 16'(ONE_Q14);
		end else if (v < -36'sd16384) begin
			r = -16'(ONE_Q14);
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: src/uvs_front.sv
module uvs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            func,
	input  logic [7:0]      grid_x,
	input  logic [7:0]      grid_y,
	input  logic [7:0]      xs,
	input  logic [7:0]      ys,
	output logic            q_valid,
	output uvs_pkg::entry_t q_head,
	input  logic            q_pop
);
	import uvs_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	entry_t         mem_q [Q_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	entry_t         ent;
	logic [7:0]     gx, gy, xm1, ym1;
	logic [8:0]     row;
	logic           wr;

	// clamp and classify the incoming request
	always_comb begin
		xm1 = xs - 8'd1;
		ym1 = ys - 8'd1;
		row = {1'b0, xs} + 9'd1;
		if (func == FUNC_QUAD) begin
			gx = (grid_x > xm1) ? xm1 : grid_x;
			gy = (grid_y > ym1) ? ym1 : grid_y;
		end else begin
			gx = (grid_x > xs) ? xs : grid_x;
			gy = (grid_y > ys) ? ys : grid_y;
		end
		ent.func = func;
		ent.gx   = gx;
		ent.gy   = gy;
		ent.tl   = 16'(gy * row) + {8'd0, gx};
		ent.bl   = 16'(gy * row) + {8'd0, gx} + {7'd0, row};
	end

	assign full    = (cnt_q == (PW+1)'(Q_DEPTH));
	assign wr      = push && !full;
	assign q_valid = (cnt_q != '0);
	assign q_head  = mem_q[rp_q];

	// hold queued requests
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= ent;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + PW'(1);
			end
			if (q_pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(q_pop);
		end
	end

`include "uv_sphere_vertex_and_index_generator_top_assert.svh"
	`UVS_ASSERT_NEVER(a_no_underflow, q_pop && !q_valid, "queue popped while empty")
	`UVS_ASSERT_NEXT(a_fill_tracks, wr && !q_pop, cnt_q == $past(cnt_q) + 1'b1, "fill count lost a write")

endmodule

// File: src/uvs_cordic.sv
module uvs_cordic #(
	parameter int ITER = uvs_pkg::ANGLE_ITERATIONS
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        ang,
	output logic signed [15:0] sine,
	output logic signed [15:0] cosine
);
	import uvs_pkg::*;

	logic signed [33:0] cx_s [ITER];
	logic signed [33:0] cy_s [ITER];
	logic signed [33:0] cz_s [ITER];
	logic               cf_s [ITER];

	logic        flip;
	logic [31:0] fang;

	// fold the angle into the right half plane
	always_comb begin
		logic [31:0] t;
		t    = ang + 32'h4000_0000;
		flip = t[31];
		fang = flip ? (ang ^ 32'h8000_0000) : ang;
	end

	for (genvar i = 0; i < ITER; i++) begin : g_it
		localparam logic signed [33:0] AT = 34'(atan_turn(i));
		logic signed [33:0] xi, yi, zi;
		logic               fi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_START;
			assign yi = '0;
			assign zi = 34'(signed'(fang));
			assign fi = flip;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign fi = cf_s[i-1];
		end
		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - AT;
				end else begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + AT;
				end
				cf_s[i] <= fi;
			end
		end
	end

	// unfold and round to Q1.14
	always_comb begin
		logic signed [35:0] xf, yf;
		xf = cf_s[ITER-1] ? -36'(cx_s[ITER-1]) : 36'(cx_s[ITER-1]);
		yf = cf_s[ITER-1] ? -36'(cy_s[ITER-1]) : 36'(cy_s[ITER-1]);
		cosine = sat_q14((xf + 36'sd32768) >>> 16);
		sine   = sat_q14((yf + 36'sd32768) >>> 16);
	end

endmodule

// File: src/uvs_back.sv
module uvs_back #(
	parameter int ITER = uvs_pkg::ANGLE_ITERATIONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       xs,
	input  logic [7:0]       ys,
	input  logic             q_valid,
	input  uvs_pkg::entry_t  q_head,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output uvs_pkg::result_t res
);
	import uvs_pkg::*;

	localparam int DS = 16;

	logic        en, issue;
	logic [2:0]  cnt_q;
	tag_t        iss_tag;
	logic [23:0] iss_nu, iss_nv;
	logic [8:0]  iss_du, iss_dv;

	logic        dvl_s [DS];
	tag_t        dtg_s [DS];
	logic [23:0] dru_s [DS];
	logic [23:0] drv_s [DS];
	logic [8:0]  ddu_s [DS];
	logic [8:0]  ddv_s [DS];
	logic [15:0] dqu_s [DS];
	logic [15:0] dqv_s [DS];

	logic        cvl_s [ITER];
	tag_t        ctg_s [ITER];
	logic [15:0] cu_s  [ITER];
	logic [15:0] cv_s  [ITER];

	logic signed [15:0] st, ct, sp, cp;

	logic               v_m1;
	tag_t               tag_m1;
	logic [15:0]        u_m1, vv_m1;
	logic signed [15:0] st_m1, ct_m1, px_m1, py_m1, pz_m1;

	logic    v_out_q;
	result_t res_q;

	assign en    = !v_out_q || pop;
	assign empty = !v_out_q;
	assign res   = res_q;
	assign issue = q_valid && en;
	assign q_pop = issue && ((q_head.func == FUNC_VERTEX) || (cnt_q == 3'd5));

	// pick the corner for this quad step
	always_comb begin
		logic [15:0] sel;
		unique case (cnt_q)
			3'd0: sel = q_head.tl;
			3'd1: sel = q_head.bl;
			3'd2: sel = q_head.tl + 16'd1;
			3'd3: sel = q_head.tl + 16'd1;
			3'd4: sel = q_head.bl;
			3'd5: sel = q_head.bl + 16'd1;
			default: sel = '0;
		endcase
		iss_tag.func  = q_head.func;
		iss_tag.last  = (q_head.func == FUNC_VERTEX) || (cnt_q == 3'd5);
		iss_tag.index = (q_head.func == FUNC_QUAD) ? sel : 16'd0;
		iss_nu = {q_head.gx, 16'd0} + {16'd0, xs};
		iss_nv = {q_head.gy, 16'd0} + {16'd0, ys};
		iss_du = {xs, 1'b0};
		iss_dv = {ys, 1'b0};
	end

	// step through the six corners of a quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (issue && (q_head.func == FUNC_QUAD)) begin
			cnt_q <= (cnt_q == 3'd5) ? 3'd0 : cnt_q + 3'd1;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < DS; j++) begin : g_div
		localparam int K = DS - 1 - j;
		logic        vi;
		tag_t        ti;
		logic [23:0] rui, rvi, shu, shv;
		logic [8:0]  dui, dvi;
		logic [15:0] qui, qvi;
		logic        geu, gev;
		if (j == 0) begin : g_first
			assign vi  = issue;
			assign ti  = iss_tag;
			assign rui = iss_nu;
			assign rvi = iss_nv;
			assign dui = iss_du;
			assign dvi = iss_dv;
			assign qui = '0;
			assign qvi = '0;
		end else begin : g_next
			assign vi  = dvl_s[j-1];
			assign ti  = dtg_s[j-1];
			assign rui = dru_s[j-1];
			assign rvi = drv_s[j-1];
			assign dui = ddu_s[j-1];
			assign dvi = ddv_s[j-1];
			assign qui = dqu_s[j-1];
			assign qvi = dqv_s[j-1];
		end
		assign shu = {15'd0, dui} << K;
		assign shv = {15'd0, dvi} << K;
		assign geu = (rui >= shu);
		assign gev = (rvi >= shv);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvl_s[j] <= 1'b0;
			end else if (en) begin
				dvl_s[j] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dtg_s[j] <= ti;
				dru_s[j] <= geu ? (rui - shu) : rui;
				drv_s[j] <= gev ? (rvi - shv) : rvi;
				ddu_s[j] <= dui;
				ddv_s[j] <= dvi;
				dqu_s[j] <= qui | (16'(geu) << K);
				dqv_s[j] <= qvi | (16'(gev) << K);
			end
		end
	end

	uvs_cordic #(.ITER(ITER)) u_theta (
		.clk    (clk),
		.en     (en),
		.ang    ({dqu_s[DS-1][14:0], 17'd0}),
		.sine   (st),
		.cosine (ct)
	);

	uvs_cordic #(.ITER(ITER)) u_phi (
		.clk    (clk),
		.en     (en),
		.ang    ({dqv_s[DS-1], 16'd0}),
		.sine   (sp),
		.cosine (cp)
	);

	// carry tags alongside the rotation stages
	for (genvar i = 0; i < ITER; i++) begin : g_tag
		logic        vi;
		tag_t        ti;
		logic [15:0] ui, wi;
		if (i == 0) begin : g_first
			assign vi = dvl_s[DS-1];
			assign ti = dtg_s[DS-1];
			assign ui = dqu_s[DS-1];
			assign wi = dqv_s[DS-1];
		end else begin : g_next
			assign vi = cvl_s[i-1];
			assign ti = ctg_s[i-1];
			assign ui = cu_s[i-1];
			assign wi = cv_s[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvl_s[i] <= 1'b0;
			end else if (en) begin
				cvl_s[i] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ctg_s[i] <= ti;
				cu_s[i]  <= ui;
				cv_s[i]  <= wi;
			end
		end
	end

	// form the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (en) begin
			v_m1 <= cvl_s[ITER-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_m1 <= ctg_s[ITER-1];
			u_m1   <= cu_s[ITER-1];
			vv_m1  <= cv_s[ITER-1];
			st_m1  <= st;
			ct_m1  <= ct;
			py_m1  <= cp;
			px_m1  <= sat_q14((36'(ct * sp) + 36'sd8192) >>> 14);
			pz_m1  <= sat_q14((36'(st * sp) + 36'sd8192) >>> 14);
		end
	end

	// form the binormal and the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [35:0] bx, by, bz;
		result_t            r;
		bx = -36'(ct_m1 * py_m1) + 36'sd8192;
		by = 36'(ct_m1 * px_m1) - 36'(st_m1 * pz_m1) + 36'sd8192;
		bz = 36'(st_m1 * py_m1) + 36'sd8192;
		r = '0;
		r.vertex_index = tag_m1.index;
		r.last         = tag_m1.last;
		if (tag_m1.func == FUNC_VERTEX) begin
			r.pos_x      = px_m1;
			r.pos_y      = py_m1;
			r.pos_z      = pz_m1;
			r.tex_u      = u_m1;
			r.tex_v      = vv_m1;
			r.tangent_x  = st_m1;
			r.tangent_z  = ct_m1;
			r.binormal_x = sat_q14(bx >>> 14);
			r.binormal_y = sat_q14(by >>> 14);
			r.binormal_z = sat_q14(bz >>> 14);
		end
		if (en) begin
			res_q <= r;
		end
	end

`include "uv_sphere_vertex_and_index_generator_top_assert.svh"
	`UVS_ASSERT_IMPLY(a_quad_step, cnt_q != 3'd0, q_valid && (q_head.func == FUNC_QUAD), "quad step without quad at head")
	`UVS_ASSERT_NEXT(a_result_held, v_out_q && !pop, v_out_q && $stable(res_q), "stalled result changed")

endmodule

// File: src/uv_sphere_vertex_and_index_generator_top.sv
// UV sphere tessellation block.
// Requests enter through a queue-style port: func, grid_x and grid_y are
// taken at a clock edge where push is high and full is low. A vertex request
// (func 0) yields one result with position, texture, tangent and binormal; a
// quad request (func 1) yields six corner indices. last marks the final
// result of each request.
// Results leave through a second queue-style port: the oldest result sits on
// the outputs while empty is low and is taken at an edge where pop is high.
// Results pass through a 16-stage divider for u and v, followed by one
// pipelined rotation stage per iteration and two multiply stages.
// Throughput is one vertex per cycle while the output is not stalled; a
// quad holds the issue slot until all six of its corners have issued.
// A four-entry request queue sits between the input and the pipeline. While a
// result is waiting and pop stays low the pipeline holds in place; the queue
// keeps taking requests until it fills, then full rises.
// Reset empties the queue and pipeline and loads 16 segments each way.
// Segment registers are written through cfg_we, cfg_index and cfg_data.
// The user must write these only while the block is idle (not enforced).
module uv_sphere_vertex_and_index_generator_top #(
	parameter int ANGLE_ITERATIONS = uvs_pkg::ANGLE_ITERATIONS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [7:0]         grid_x,
	input  logic [7:0]         grid_y,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic [15:0]        tex_u,
	output logic [15:0]        tex_v,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_z,
	output logic signed [15:0] binormal_x,
	output logic signed [15:0] binormal_y,
	output logic signed [15:0] binormal_z,
	output logic [15:0]        vertex_index,
	output logic               last
);
	import uvs_pkg::*;

	logic [7:0]  x_segments_q, y_segments_q, xs, ys;
	logic [23:0] vertex_color_q;
	logic        q_valid, q_pop;
	entry_t      q_head;
	result_t     res;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_segments_q   <= 8'd16;
			y_segments_q   <= 8'd16;
			vertex_color_q <= 24'hFF_FFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_SEGMENTS:   x_segments_q   <= cfg_data[7:0];
				REG_Y_SEGMENTS:   y_segments_q   <= cfg_data[7:0];
				REG_VERTEX_COLOR: vertex_color_q <= cfg_data;
				default: vertex_color_q <= vertex_color_q;
			endcase
		end
	end

	// zero acts as one, large counts are capped
	always_comb begin
		xs = (x_segments_q == 8'd0) ? 8'd1 : x_segments_q;
		ys = (y_segments_q == 8'd0) ? 8'd1 : y_segments_q;
		if (xs > 8'(MAX_SEGMENTS)) begin
			xs = 8'(MAX_SEGMENTS);
		end
		if (ys > 8'(MAX_SEGMENTS)) begin
			ys = 8'(MAX_SEGMENTS);
		end
	end

	uvs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.func    (func),
		.grid_x  (grid_x),
		.grid_y  (grid_y),
		.xs      (xs),
		.ys      (ys),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	uvs_back #(.ITER(ANGLE_ITERATIONS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.xs      (xs),
		.ys      (ys),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign pos_x        = res.pos_x;
	assign pos_y        = res.pos_y;
	assign pos_z        = res.pos_z;
	assign tex_u        = res.tex_u;
	assign tex_v        = res.tex_v;
	assign tangent_x    = res.tangent_x;
	assign tangent_z    = res.tangent_z;
	assign binormal_x   = res.binormal_x;
	assign binormal_y   = res.binormal_y;
	assign binormal_z   = res.binormal_z;
	assign vertex_index = res.vertex_index;
	assign last         = res.last;

`include "uv_sphere_vertex_and_index_generator_top_assert.svh"
	`UVS_ASSERT_NEVER(a_seg_nonzero, (xs == 8'd0) || (ys == 8'd0), "segment count reached zero")

endmodule
